// ===== sv/hip_pkg.sv =====
// Shared types, constants and helpers for the Hilbert step-to-point pipeline.
// Holds the orientation table and the per-stage digit walk; no dependencies.
package hip_pkg;

  localparam int STEP_W     = 32;
  localparam int COORD_W    = 32;
  localparam int MAX_RANK   = 15;
  localparam int RANK_W     = 4;
  localparam int NUM_LVL    = MAX_RANK + 1;
  localparam int GRID_W     = NUM_LVL;
  localparam int LVL_PER_ST = 4;
  localparam int WALK_ST    = NUM_LVL / LVL_PER_ST;
  localparam int NUM_ST     = WALK_ST + 2;
  localparam int PROD_W     = COORD_W + GRID_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int DIR_W      = 2;

  localparam logic [COORD_W-1:0] UNIT_RST = COORD_W'(65536);
  localparam logic [RANK_W-1:0]  RANK_RST = RANK_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANK,
    CFG_UNIT,
    CFG_ORG_X,
    CFG_ORG_Y,
    CFG_START_DIR
  } hip_cfg_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_R,
    DIR_L,
    DIR_D,
    DIR_U
  } hip_dir_e;

  typedef struct packed {
    logic     x;
    logic     y;
    hip_dir_e nxt;
  } hip_ent_t;

  typedef struct packed {
    hip_dir_e              dir;
    logic [LVL_PER_ST-1:0] x;
    logic [LVL_PER_ST-1:0] y;
  } hip_walk_t;

  typedef struct packed {
    logic [COORD_W-1:0] val;
    logic               sat;
  } hip_pt_t;

  // Quadrant offset and next orientation for one level.
  function automatic hip_ent_t hip_lookup(hip_dir_e dir, logic [1:0] digit);
    hip_ent_t e;
    unique case ({dir, digit})
      {DIR_R, 2'd0}: e = '{x: 1'b0, y: 1'b1, nxt: DIR_U};
      {DIR_R, 2'd1}: e = '{x: 1'b1, y: 1'b1, nxt: DIR_R};
      {DIR_R, 2'd2}: e = '{x: 1'b1, y: 1'b0, nxt: DIR_R};
      {DIR_R, 2'd3}: e = '{x: 1'b0, y: 1'b0, nxt: DIR_D};
      {DIR_L, 2'd0}: e = '{x: 1'b1, y: 1'b0, nxt: DIR_D};
      {DIR_L, 2'd1}: e = '{x: 1'b0, y: 1'b0, nxt: DIR_L};
      {DIR_L, 2'd2}: e = '{x: 1'b0, y: 1'b1, nxt: DIR_L};
      {DIR_L, 2'd3}: e = '{x: 1'b1, y: 1'b1, nxt: DIR_U};
      {DIR_D, 2'd0}: e = '{x: 1'b1, y: 1'b0, nxt: DIR_L};
      {DIR_D, 2'd1}: e = '{x: 1'b1, y: 1'b1, nxt: DIR_D};
      {DIR_D, 2'd2}: e = '{x: 1'b0, y: 1'b1, nxt: DIR_D};
      {DIR_D, 2'd3}: e = '{x: 1'b0, y: 1'b0, nxt: DIR_R};
      {DIR_U, 2'd0}: e = '{x: 1'b0, y: 1'b1, nxt: DIR_R};
      {DIR_U, 2'd1}: e = '{x: 1'b0, y: 1'b0, nxt: DIR_U};
      {DIR_U, 2'd2}: e = '{x: 1'b1, y: 1'b0, nxt: DIR_U};
      {DIR_U, 2'd3}: e = '{x: 1'b1, y: 1'b1, nxt: DIR_L};
      default:       e = '{x: 1'b0, y: 1'b0, nxt: DIR_R};
    endcase
    return e;
  endfunction

  // Walk LVL_PER_ST levels, top level first; levels above rank leave all as is.
  function automatic hip_walk_t hip_walk(hip_dir_e dir, logic [2*LVL_PER_ST-1:0] dig,
                                         logic [RANK_W-1:0] base,
                                         logic [RANK_W-1:0] rank);
    hip_walk_t         w;
    hip_ent_t          e;
    logic [RANK_W-1:0] lvl;
    w.dir = dir;
    w.x   = '0;
    w.y   = '0;
    for (int i = LVL_PER_ST - 1; i >= 0; i--) begin
      lvl = base + RANK_W'(i);
      if (lvl <= rank) begin
        e      = hip_lookup(w.dir, dig[2*i +: 2]);
        w.x[i] = e.x;
        w.y[i] = e.y;
        w.dir  = e.nxt;
      end
    end
    return w;
  endfunction

  // Signed origin plus unsigned product, clamped to the 32-bit range.
  function automatic hip_pt_t hip_sat(logic [COORD_W-1:0] origin, logic [PROD_W-1:0] prod);
    hip_pt_t          r;
    logic [SUM_W-1:0] sum;
    sum = {{(SUM_W - COORD_W){origin[COORD_W-1]}}, origin} + {1'b0, prod};
    if (sum[SUM_W-1:COORD_W-1] == '0 || sum[SUM_W-1:COORD_W-1] == '1) begin
      r.val = sum[COORD_W-1:0];
      r.sat = 1'b0;
    end else if (sum[SUM_W-1]) begin
      r.val = {1'b1, {(COORD_W - 1){1'b0}}};
      r.sat = 1'b1;
    end else begin
      r.val = {1'b0, {(COORD_W - 1){1'b1}}};
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== sv/hilbert_index_to_point.sv =====
// Hilbert step-to-point mapper: maps each input step word to an output point word.
// Throughput one word per cycle while the output is not stalled; four walk stages of four levels each, then a
// 32x16 multiply stage and an add/saturate stage that is the output register.
// A stalled output fills empty stages first; ready drops only when all are full.
// Reset empties the pipeline and loads rank 5, unit 1.0, origin 0, direction U.
// Depends on hip_pkg.
module hilbert_index_to_point (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hip_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hip_pkg::COORD_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [hip_pkg::STEP_W-1:0]       step_number_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [hip_pkg::COORD_W-1:0] point_x_o,
  output logic signed [hip_pkg::COORD_W-1:0] point_y_o,
  output logic [hip_pkg::GRID_W-1:0]       grid_x_o,
  output logic [hip_pkg::GRID_W-1:0]       grid_y_o,
  output logic                             is_final_o,
  output logic                             out_of_range_o
);
  import hip_pkg::*;

  // Configuration registers
  logic [RANK_W-1:0]  cfg_rank_q, cfg_rank_d;
  logic [COORD_W-1:0] cfg_unit_q, cfg_unit_d;
  logic [COORD_W-1:0] cfg_org_x_q, cfg_org_x_d;
  logic [COORD_W-1:0] cfg_org_y_q, cfg_org_y_d;
  logic [DIR_W-1:0]   cfg_dir_q, cfg_dir_d;

  // Pipeline control
  logic [NUM_ST-1:0] vld_q, vld_d;
  logic [NUM_ST-1:0] en;

  // Walk stages
  hip_dir_e           dir_q  [WALK_ST];
  hip_dir_e           dir_d  [WALK_ST];
  logic [GRID_W-1:0]  gx_q   [WALK_ST];
  logic [GRID_W-1:0]  gx_d   [WALK_ST];
  logic [GRID_W-1:0]  gy_q   [WALK_ST];
  logic [GRID_W-1:0]  gy_d   [WALK_ST];
  logic [STEP_W-1:0]  step_q [WALK_ST];
  logic [STEP_W-1:0]  step_d [WALK_ST];
  logic [WALK_ST-1:0] over_q, over_d;
  logic [WALK_ST-1:0] fin_q, fin_d;

  // Multiply stage
  logic [PROD_W-1:0] prod_x_q, prod_x_d;
  logic [PROD_W-1:0] prod_y_q, prod_y_d;
  logic [GRID_W-1:0] mgx_q, mgy_q;
  logic              mover_q, mfin_q;

  // Output stage
  logic [COORD_W-1:0] pt_x_q, pt_x_d;
  logic [COORD_W-1:0] pt_y_q, pt_y_d;
  logic [GRID_W-1:0]  ogx_q, ogy_q;
  logic               ofin_q;
  logic               orng_q, orng_d;

  // Range check on the raw step
  logic [RANK_W+1:0]  nbits;
  logic [STEP_W:0]    last_step;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_rank_d  = cfg_rank_q;
    cfg_unit_d  = cfg_unit_q;
    cfg_org_x_d = cfg_org_x_q;
    cfg_org_y_d = cfg_org_y_q;
    cfg_dir_d   = cfg_dir_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RANK:      cfg_rank_d  = cfg_data_i[RANK_W-1:0];
        CFG_UNIT:      cfg_unit_d  = cfg_data_i;
        CFG_ORG_X:     cfg_org_x_d = cfg_data_i;
        CFG_ORG_Y:     cfg_org_y_d = cfg_data_i;
        CFG_START_DIR: cfg_dir_d   = cfg_data_i[DIR_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // A stage advances when it is empty or the next one advances.
  always_comb begin
    en[NUM_ST-1] = !vld_q[NUM_ST-1] || out_ready_i;
    for (int k = NUM_ST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NUM_ST; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  assign in_ready_o = en[0];

  assign nbits     = ({2'b0, cfg_rank_q} + (RANK_W + 2)'(1)) << 1;
  assign last_step = ({{STEP_W{1'b0}}, 1'b1} << nbits) - (STEP_W + 1)'(1);

  always_comb begin
    hip_walk_t         w;
    hip_dir_e          src_dir;
    logic [GRID_W-1:0] src_gx;
    logic [GRID_W-1:0] src_gy;
    logic [STEP_W-1:0] src_step;
    int                base;
    for (int s = 0; s < WALK_ST; s++) begin
      base = NUM_LVL - LVL_PER_ST * (s + 1);
      if (s == 0) begin
        src_dir   = hip_dir_e'(cfg_dir_q);
        src_gx    = '0;
        src_gy    = '0;
        src_step  = step_number_i;
        over_d[s] = |({1'b0, step_number_i} & ~last_step);
        fin_d[s]  = ({1'b0, step_number_i} == last_step);
      end else begin
        src_dir   = dir_q[s-1];
        src_gx    = gx_q[s-1];
        src_gy    = gy_q[s-1];
        src_step  = step_q[s-1];
        over_d[s] = over_q[s-1];
        fin_d[s]  = fin_q[s-1];
      end
      w = hip_walk(src_dir, src_step[2*base +: 2*LVL_PER_ST], RANK_W'(base), cfg_rank_q);
      dir_d[s]  = w.dir;
      gx_d[s]   = src_gx;
      gy_d[s]   = src_gy;
      gx_d[s][base +: LVL_PER_ST] = w.x;
      gy_d[s][base +: LVL_PER_ST] = w.y;
      step_d[s] = src_step;
    end
  end

  assign prod_x_d = {{GRID_W{1'b0}}, cfg_unit_q} * {{COORD_W{1'b0}}, gx_q[WALK_ST-1]};
  assign prod_y_d = {{GRID_W{1'b0}}, cfg_unit_q} * {{COORD_W{1'b0}}, gy_q[WALK_ST-1]};

  always_comb begin
    hip_pt_t px;
    hip_pt_t py;
    px     = hip_sat(cfg_org_x_q, prod_x_q);
    py     = hip_sat(cfg_org_y_q, prod_y_q);
    pt_x_d = px.val;
    pt_y_d = py.val;
    orng_d = mover_q || px.sat || py.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      cfg_rank_q  <= RANK_RST;
      cfg_unit_q  <= UNIT_RST;
      cfg_org_x_q <= '0;
      cfg_org_y_q <= '0;
      cfg_dir_q   <= DIR_U;
    end else begin
      vld_q       <= vld_d;
      cfg_rank_q  <= cfg_rank_d;
      cfg_unit_q  <= cfg_unit_d;
      cfg_org_x_q <= cfg_org_x_d;
      cfg_org_y_q <= cfg_org_y_d;
      cfg_dir_q   <= cfg_dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < WALK_ST; s++) begin
      if (en[s]) begin
        dir_q[s]  <= dir_d[s];
        gx_q[s]   <= gx_d[s];
        gy_q[s]   <= gy_d[s];
        step_q[s] <= step_d[s];
        over_q[s] <= over_d[s];
        fin_q[s]  <= fin_d[s];
      end
    end
    if (en[WALK_ST]) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      mgx_q    <= gx_q[WALK_ST-1];
      mgy_q    <= gy_q[WALK_ST-1];
      mover_q  <= over_q[WALK_ST-1];
      mfin_q   <= fin_q[WALK_ST-1];
    end
    if (en[NUM_ST-1]) begin
      pt_x_q <= pt_x_d;
      pt_y_q <= pt_y_d;
      ogx_q  <= mgx_q;
      ogy_q  <= mgy_q;
      ofin_q <= mfin_q;
      orng_q <= orng_d;
    end
  end

  assign out_valid_o    = vld_q[NUM_ST-1];
  assign point_x_o      = pt_x_q;
  assign point_y_o      = pt_y_q;
  assign grid_x_o       = ogx_q;
  assign grid_y_o       = ogy_q;
  assign is_final_o     = ofin_q;
  assign out_of_range_o = orng_q;

  // The last point of the curve is never beyond it.
  a_fin_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && fin_q[0] |-> !over_q[0])
    else $error("final step flagged out of range");

  // Grid bits above the configured rank stay clear after the walk.
  a_grid_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[WALK_ST-1] |->
      ((gx_q[WALK_ST-1] >> ({1'b0, cfg_rank_q} + (RANK_W + 1)'(1))) == '0) &&
      ((gy_q[WALK_ST-1] >> ({1'b0, cfg_rank_q} + (RANK_W + 1)'(1))) == '0))
    else $error("grid coordinate wider than rank");

  // Input is refused only when every stage holds a word.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q))
    else $error("input stalled with an empty stage");

  // The second walk stage, when held, keeps its word.
  a_hold_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !en[1] |=> vld_q[1] && $stable(gx_q[1]) && $stable(step_q[1]))
    else $error("stalled walk stage lost its word");

endmodule
